/* hdl/ttpe_pkg.sv */
// Shared constants, types and command/status structs of the tap tempo period estimator.
package ttpe_pkg;

    localparam int TAP_DEPTH_DEF = 10;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd250;
    localparam logic [15:0] WINDOW_RESET   = 16'd5000;
    localparam logic [15:0] PERIOD_RESET   = 16'd500;
    localparam logic [15:0] TEMPO_RESET    = 16'd15360;
    localparam logic [31:0] TEMPO_NUM      = 32'd7680000;
    localparam logic [15:0] SAT16          = 16'hFFFF;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEBOUNCE = 1'b0;
    localparam t_cfg_idx CFG_WINDOW   = 1'b1;

    typedef enum logic {
        DIV_AVG,
        DIV_TEMPO
    } t_div_sel;

    typedef struct packed {
        logic     cap;
        logic     check;
        logic     walk;
        logic     acc;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_avg;
        logic     take_tempo;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bounce;
        logic cnt_zero;
        logic div_done;
    } t_dp_sts;

    typedef struct packed {
        logic        accepted;
        logic        updated;
        logic [15:0] period_ms;
        logic [15:0] tempo_q8;
        logic [3:0]  intervals_used;
        logic [31:0] beat_phase_time;
    } t_result;

endpackage

/* hdl/ttpe_in_if.sv */
// Tap input channel: valid/ready handshake with the tap timestamp.
interface ttpe_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] tap_time;

    modport source (output valid, output tap_time, input ready);
    modport sink   (input valid, input tap_time, output ready);
endinterface

/* hdl/ttpe_out_if.sv */
// Result output channel: valid/ready handshake with period, tempo and phase fields.
interface ttpe_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        updated;
    logic [15:0] period_ms;
    logic [15:0] tempo_q8;
    logic [3:0]  intervals_used;
    logic [31:0] beat_phase_time;

    modport source (
        output valid, output accepted, output updated, output period_ms,
        output tempo_q8, output intervals_used, output beat_phase_time,
        input ready
    );
    modport sink (
        input valid, input accepted, input updated, input period_ms,
        input tempo_q8, input intervals_used, input beat_phase_time,
        output ready
    );
endinterface

/* hdl/ttpe_div.sv */
// Shared restoring divider: 16 quotient bits, one per cycle, with saturation precheck.
module ttpe_div #(
    parameter int SUM_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [15:0]      i_divisor,
    output logic             o_done,
    output logic             o_ovf,
    output logic [15:0]      o_quo
);
    import ttpe_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic                 r_ovf;
    logic [15:0]          r_div;
    logic [15:0]          r_rem;
    logic [15:0]          r_low;
    logic [15:0]          n_rem;
    logic                 n_qbit;
    logic [16:0]          w_trial;
    logic                 w_ovf;

    assign w_ovf   = i_dividend >= SUM_W'({i_divisor, 16'b0});
    assign w_trial = {r_rem, r_low[15]};

    always_comb begin
        if (w_trial >= {1'b0, r_div}) begin
            n_rem  = 16'(w_trial - {1'b0, r_div});
            n_qbit = 1'b1;
        end else begin
            n_rem  = w_trial[15:0];
            n_qbit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div <= i_divisor;
                r_ovf <= w_ovf;
                if (w_ovf) begin
                    r_cnt  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_rem <= 16'(i_dividend[SUM_W-1:16]);
                    r_low <= i_dividend[15:0];
                    r_cnt <= DIV_CNT_W'(DIV_STEPS);
                end
            end else if (r_cnt != '0) begin
                r_rem <= n_rem;
                r_low <= {r_low[14:0], n_qbit};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quo  = r_low;
endmodule

/* hdl/ttpe_dp.sv */
// Datapath: tap history, interval walk, period and tempo registers, result register.
module ttpe_dp #(
    parameter int TAP_DEPTH = ttpe_pkg::TAP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttpe_pkg::t_dp_cmd i_cmd,
    output ttpe_pkg::t_dp_sts o_sts,
    input  logic [31:0]       i_tap_time,
    input  logic              i_cfg_we,
    input  ttpe_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output ttpe_pkg::t_result o_res
);
    import ttpe_pkg::*;

    localparam int CNT_W = $clog2(TAP_DEPTH);
    localparam int SUM_W = 32 + $clog2(TAP_DEPTH);

    logic [31:0]      r_hist [TAP_DEPTH];
    logic [31:0]      r_tap;
    logic [31:0]      r_limit;
    logic [31:0]      r_phase;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_active;
    logic             r_accepted;
    logic             r_updated;
    logic [15:0]      r_period;
    logic [15:0]      r_tempo;
    logic [15:0]      r_deb;
    logic [15:0]      r_win;
    t_result          r_out;

    logic [31:0]      w_deb_sum;
    logic             w_bounce;
    logic [31:0]      w_ivl;
    logic [SUM_W-1:0] w_dividend;
    logic [15:0]      w_divisor;
    logic             w_div_done;
    logic             w_div_ovf;
    logic [15:0]      w_div_quo;

    assign w_deb_sum = r_hist[0] + {16'b0, r_deb};
    assign w_bounce  = w_deb_sum > r_tap;
    assign w_ivl     = r_hist[0] - r_hist[1];

    assign w_dividend = (i_cmd.div_sel == DIV_AVG) ? r_sum : SUM_W'(TEMPO_NUM);
    assign w_divisor  = (i_cmd.div_sel == DIV_AVG) ? 16'(r_cnt) : r_period;

    ttpe_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_ovf      (w_div_ovf),
        .o_quo      (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAP_DEPTH; j++) begin
                r_hist[j] <= '0;
            end
            r_period <= PERIOD_RESET;
            r_tempo  <= TEMPO_RESET;
            r_deb    <= DEBOUNCE_RESET;
            r_win    <= WINDOW_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEBOUNCE: r_deb <= i_cfg_data;
                    CFG_WINDOW:   r_win <= i_cfg_data;
                endcase
            end
            if (i_cmd.cap) begin
                r_tap <= i_tap_time;
            end
            if (i_cmd.check) begin
                r_sum      <= '0;
                r_cnt      <= '0;
                r_active   <= 1'b1;
                r_updated  <= 1'b0;
                r_accepted <= !w_bounce;
                r_phase    <= w_bounce ? 32'b0 : r_tap - {16'b0, r_period};
                r_limit    <= r_tap - {16'b0, r_win};
                if (!w_bounce) begin
                    r_hist[0] <= r_tap;
                    for (int j = 1; j < TAP_DEPTH; j++) begin
                        r_hist[j] <= r_hist[j-1];
                    end
                end
            end
            if (i_cmd.walk) begin
                for (int j = 0; j < TAP_DEPTH - 1; j++) begin
                    r_hist[j] <= r_hist[j+1];
                end
                r_hist[TAP_DEPTH-1] <= r_hist[0];
                if (i_cmd.acc && r_active) begin
                    if (r_hist[1] > r_limit) begin
                        r_sum <= r_sum + SUM_W'(w_ivl);
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_active <= 1'b0;
                    end
                end
            end
            if (i_cmd.take_avg && w_div_done) begin
                r_period  <= w_div_ovf ? SAT16 : w_div_quo;
                r_updated <= 1'b1;
            end
            if (i_cmd.take_tempo && w_div_done) begin
                r_tempo <= w_div_ovf ? SAT16 : w_div_quo;
            end
            if (i_cmd.out_load) begin
                r_out.accepted        <= r_accepted;
                r_out.updated         <= r_updated;
                r_out.period_ms       <= r_period;
                r_out.tempo_q8        <= r_tempo;
                r_out.intervals_used  <= 4'(r_cnt);
                r_out.beat_phase_time <= r_phase;
            end
        end
    end

    assign o_sts.bounce   = w_bounce;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.div_done = w_div_done;
    assign o_res          = r_out;
endmodule

/* hdl/ttpe_ctrl.sv */
// Controller: sequences capture, debounce, history walk, two divisions and result transfer.
module ttpe_ctrl #(
    parameter int TAP_DEPTH = ttpe_pkg::TAP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ttpe_pkg::t_dp_sts i_sts,
    output ttpe_pkg::t_dp_cmd o_cmd
);
    import ttpe_pkg::*;

    localparam int STEP_W = $clog2(TAP_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TAP_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_SETUP,
        S_DIV_AVG,
        S_TMP_START,
        S_DIV_TMP,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_AVG;
        unique case (r_state)
            S_IDLE:      o_cmd.cap = i_in_valid;
            S_CHECK:     o_cmd.check = 1'b1;
            S_WALK: begin
                o_cmd.walk = 1'b1;
                o_cmd.acc  = (r_step != LAST_STEP);
            end
            S_SETUP:     o_cmd.div_start = !i_sts.cnt_zero;
            S_DIV_AVG:   o_cmd.take_avg = 1'b1;
            S_TMP_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_TEMPO;
            end
            S_DIV_TMP: begin
                o_cmd.take_tempo = 1'b1;
                o_cmd.div_sel    = DIV_TEMPO;
            end
            S_DONE:      o_cmd.out_load = w_out_free;
            default:     o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_step  <= '0;
                    r_state <= i_sts.bounce ? S_DONE : S_WALK;
                end
                S_WALK: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= i_sts.cnt_zero ? S_DONE : S_DIV_AVG;
                end
                S_DIV_AVG: begin
                    if (i_sts.div_done) begin
                        r_state <= S_TMP_START;
                    end
                end
                S_TMP_START: r_state <= S_DIV_TMP;
                S_DIV_TMP: begin
                    if (i_sts.div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

/* hdl/tap_tempo_period_estimator.sv */
// Top level of the tap tempo period estimator: controller, datapath and channel ports.
//
//   channel   dir   handshake              payload
//   i_tap     in    valid/ready            tap_time[31:0]
//   o_res     out   valid/ready            accepted, updated, period_ms, tempo_q8,
//                                          intervals_used, beat_phase_time
//   i_cfg_*   in    write enable only      idx 0 debounce_ms, idx 1 window_ms
//
// An ignored tap goes from the check straight to the result; an accepted tap walks the
// whole history and, when intervals count, runs two divider waits (16 quotient bits
// each) with a start step between them. A saturating quotient skips the bit steps.
// Reset clears the history, sets period 500, tempo 15360 and the register defaults.
// The result register frees the input side: a new tap transfers while a result waits.
// A stalled result holds the block in its last step until the output transfer.
module tap_tempo_period_estimator #(
    parameter int TAP_DEPTH = ttpe_pkg::TAP_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ttpe_in_if.sink            i_tap,
    ttpe_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  ttpe_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import ttpe_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_result w_res;

    ttpe_ctrl #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tap.valid),
        .o_in_ready  (i_tap.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ttpe_dp #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_tap_time (i_tap.tap_time),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (w_res)
    );

    assign o_res.accepted        = w_res.accepted;
    assign o_res.updated         = w_res.updated;
    assign o_res.period_ms       = w_res.period_ms;
    assign o_res.tempo_q8        = w_res.tempo_q8;
    assign o_res.intervals_used  = w_res.intervals_used;
    assign o_res.beat_phase_time = w_res.beat_phase_time;
endmodule
